>>> rtl/core/json_string_unescape_utf8_macros.svh
// Assertion macros for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("jsu assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("jsu assertion failed: next-cycle implication");

`endif

>>> rtl/core/jsu_pkg.sv
// Types, codes and character constants of the JSON string unescaper.
package jsu_pkg;

	// Decoder phase
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_STR     = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX1    = 4'd3,
		PH_PAIR_BS = 4'd4,
		PH_PAIR_U  = 4'd5,
		PH_HEX2    = 4'd6
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_EXP_QUOTE   = 4'd1;
	localparam logic [3:0] ERR_UNTERM_STR  = 4'd2;
	localparam logic [3:0] ERR_CTRL_CHAR   = 4'd3;
	localparam logic [3:0] ERR_UNTERM_ESC  = 4'd4;
	localparam logic [3:0] ERR_BAD_ESC     = 4'd5;
	localparam logic [3:0] ERR_TRUNC_HEX   = 4'd6;
	localparam logic [3:0] ERR_BAD_HEX     = 4'd7;
	localparam logic [3:0] ERR_LONE_HIGH   = 4'd8;
	localparam logic [3:0] ERR_BAD_LOW     = 4'd9;

	// Characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Surrogate and UTF-8 limits
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [20:0] LIM_1BYTE  = 21'h80;
	localparam logic [20:0] LIM_2BYTE  = 21'h800;
	localparam logic [20:0] LIM_3BYTE  = 21'h10000;

	// Results per request at most
	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [3:0] error_code;
		logic       last;
	} rsp_t;

endpackage

>>> rtl/core/json_string_unescape_utf8.sv
// JSON string unescaper: raw string bytes in, UTF-8 bytes and status out.
//
//  channel | handshake             | payload | per request
//  --------+-----------------------+---------+-----------------------------
//  req     | req_valid / req_ready | req_t   | one raw byte or end marker
//  rsp     | rsp_valid / rsp_ready | rsp_t   | 0 to 4 results, last marked
//
// A request is registered, decoded combinationally against the phase registers
// and its results are written as one row into a two-row result queue.
// Requests flow one per cycle; a request that yields results waits in the input
// register while both rows are occupied; each row drains one result a cycle
// while rsp_ready is high.
// Reset clears phase, input valid flag and queue pointers; no clearing pass.
module json_string_unescape_utf8 import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Input register
	logic valid_s1;
	req_t req_s1;

	// Decoder state
	phase_t      phase_q, phase_n;
	logic [1:0]  hex_count_q, hex_count_n;
	logic [15:0] code_accum_q, code_accum_n;
	logic [9:0]  high_saved_q, high_saved_n;

	// Decode outputs
	rsp_t        res_c [MAX_RES];
	logic [2:0]  n_c;
	logic [1:0]  last_idx;

	// Helpers
	logic [7:0]  c;
	logic        eoi;
	logic        hex_ok;
	logic [3:0]  hex_d;
	logic [15:0] v;
	logic        utf_en;
	logic [20:0] cp;
	logic        err_en;
	logic [3:0]  err_c;

	// Result queue
	rsp_t        rows_q [2][MAX_RES];
	logic [1:0]  cnt_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  idx_q;

	logic s1_go;
	logic push;
	logic pop;
	logic rsp_fire;
	logic req_fire;

	assign c   = req_s1.data_byte;
	assign eoi = req_s1.end_of_input;

	// Hex digit value
	always_comb begin
		hex_ok = 1'b1;
		hex_d  = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			hex_d = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_d = c[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign v = {code_accum_q[11:0], hex_d};

	// Next phase and results of the registered request
	always_comb begin
		phase_n      = phase_q;
		hex_count_n  = hex_count_q;
		code_accum_n = code_accum_q;
		high_saved_n = high_saved_q;
		utf_en       = 1'b0;
		cp           = '0;
		err_en       = 1'b0;
		err_c        = ERR_NONE;
		n_c          = 3'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_c[i] = '0;
		end

		case (phase_q)
			PH_STR: begin
				if (eoi) begin
					err_en = 1'b1;
					err_c  = ERR_UNTERM_STR;
				end else if (c == CH_QUOTE) begin
					phase_n        = PH_IDLE;
					res_c[0].kind  = KIND_DONE;
					n_c            = 3'd1;
				end else if (c < CH_SPACE) begin
					err_en = 1'b1;
					err_c  = ERR_CTRL_CHAR;
				end else if (c == CH_BSLASH) begin
					phase_n = PH_ESC;
				end else begin
					res_c[0].out_byte = c;
					n_c               = 3'd1;
				end
			end
			PH_ESC: begin
				if (eoi) begin
					err_en = 1'b1;
					err_c  = ERR_UNTERM_ESC;
				end else begin
					phase_n = PH_STR;
					n_c     = 3'd1;
					case (c)
						CH_QUOTE:  res_c[0].out_byte = CH_QUOTE;
						CH_BSLASH: res_c[0].out_byte = CH_BSLASH;
						CH_SLASH:  res_c[0].out_byte = CH_SLASH;
						CH_B:      res_c[0].out_byte = 8'h08;
						CH_F:      res_c[0].out_byte = 8'h0C;
						CH_N:      res_c[0].out_byte = 8'h0A;
						CH_R:      res_c[0].out_byte = 8'h0D;
						CH_T:      res_c[0].out_byte = 8'h09;
						CH_U: begin
							phase_n      = PH_HEX1;
							hex_count_n  = 2'd0;
							code_accum_n = 16'd0;
							n_c          = 3'd0;
						end
						default: begin
							n_c    = 3'd0;
							err_en = 1'b1;
							err_c  = ERR_BAD_ESC;
						end
					endcase
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (eoi) begin
					err_en = 1'b1;
					err_c  = ERR_TRUNC_HEX;
				end else if (!hex_ok) begin
					err_en = 1'b1;
					err_c  = ERR_BAD_HEX;
				end else begin
					code_accum_n = v;
					if (hex_count_q != 2'd3) begin
						hex_count_n = hex_count_q + 2'd1;
					end else begin
						hex_count_n = 2'd0;
						if (phase_q == PH_HEX1) begin
							if (v >= HIGH_FIRST && v <= HIGH_LAST) begin
								high_saved_n = v[9:0];
								phase_n      = PH_PAIR_BS;
							end else begin
								phase_n = PH_STR;
								utf_en  = 1'b1;
								cp      = {5'd0, v};
							end
						end else begin
							if (v >= LOW_FIRST && v <= LOW_LAST) begin
								phase_n = PH_STR;
								utf_en  = 1'b1;
								cp      = {1'b0, high_saved_q, v[9:0]} + SUPP_BASE;
							end else begin
								err_en = 1'b1;
								err_c  = ERR_BAD_LOW;
							end
						end
					end
				end
			end
			PH_PAIR_BS: begin
				if (eoi || c != CH_BSLASH) begin
					err_en = 1'b1;
					err_c  = ERR_LONE_HIGH;
				end else begin
					phase_n = PH_PAIR_U;
				end
			end
			PH_PAIR_U: begin
				if (eoi || c != CH_U) begin
					err_en = 1'b1;
					err_c  = ERR_LONE_HIGH;
				end else begin
					phase_n      = PH_HEX2;
					hex_count_n  = 2'd0;
					code_accum_n = 16'd0;
				end
			end
			default: begin
				// Idle and unused codes: wait for the opening quote
				if (eoi || c != CH_QUOTE) begin
					err_en = 1'b1;
					err_c  = ERR_EXP_QUOTE;
				end else begin
					phase_n = PH_STR;
				end
			end
		endcase

		// Report an error and return to idle
		if (err_en) begin
			phase_n             = PH_IDLE;
			res_c[0].kind       = KIND_ERROR;
			res_c[0].error_code = err_c;
			n_c                 = 3'd1;
		end

		// Encode the code point as UTF-8
		if (utf_en) begin
			if (cp < LIM_1BYTE) begin
				res_c[0].out_byte = cp[7:0];
				n_c               = 3'd1;
			end else if (cp < LIM_2BYTE) begin
				res_c[0].out_byte = {3'b110, cp[10:6]};
				res_c[1].out_byte = {2'b10, cp[5:0]};
				n_c               = 3'd2;
			end else if (cp < LIM_3BYTE) begin
				res_c[0].out_byte = {4'b1110, cp[15:12]};
				res_c[1].out_byte = {2'b10, cp[11:6]};
				res_c[2].out_byte = {2'b10, cp[5:0]};
				n_c               = 3'd3;
			end else begin
				res_c[0].out_byte = {5'b11110, cp[20:18]};
				res_c[1].out_byte = {2'b10, cp[17:12]};
				res_c[2].out_byte = {2'b10, cp[11:6]};
				res_c[3].out_byte = {2'b10, cp[5:0]};
				n_c               = 3'd4;
			end
		end

		// Mark the final result of this request
		last_idx = n_c[1:0] - 2'd1;
		if (n_c != 3'd0) begin
			res_c[last_idx].last = 1'b1;
		end
	end

	// Handshakes
	assign s1_go     = valid_s1 && (n_c == 3'd0 || cnt_q != 2'd2);
	assign req_ready = !valid_s1 || s1_go;
	assign req_fire  = req_valid && req_ready;
	assign push      = s1_go && (n_c != 3'd0);
	assign rsp_valid = cnt_q != 2'd0;
	assign rsp       = rows_q[rd_ptr_q][idx_q];
	assign rsp_fire  = rsp_valid && rsp_ready;
	assign pop       = rsp_fire && rsp.last;

	// Phase registers: advance when the registered request is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hex_count_q  <= 2'd0;
			code_accum_q <= 16'd0;
			high_saved_q <= 10'd0;
		end else if (s1_go) begin
			phase_q      <= phase_n;
			hex_count_q  <= hex_count_n;
			code_accum_q <= code_accum_n;
			high_saved_q <= high_saved_n;
		end
	end

	// Input register: load on accept, drop when consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
	end

	// Result rows: write one row per request that yields results
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RES; i++) begin
				rows_q[wr_ptr_q][i] <= res_c[i];
			end
		end
	end

	// Queue pointers and drain index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			idx_q    <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (rsp_fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker import jsu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	logic is_status;
	logic is_error;
	logic err_clean;

	// Classify the result on the port
	assign is_status = rsp_valid && rsp.kind != KIND_BYTE;
	assign is_error  = rsp_valid && rsp.kind == KIND_ERROR;
	assign err_clean = rsp.error_code >= ERR_EXP_QUOTE && rsp.error_code <= ERR_BAD_LOW
		&& rsp.out_byte == 8'h00;

	// Hold a stalled result
	`JSU_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// Completion and error always close a request's results
	`JSU_ASSERT_IMPL(a_status_last, clk, arst_n, is_status, rsp.last)

	// Decoded bytes and completions carry no error code
	`JSU_ASSERT_IMPL(a_no_err_code, clk, arst_n, rsp_valid && !is_error, rsp.error_code == ERR_NONE)

	// Errors carry a known code and a zero byte
	`JSU_ASSERT_IMPL(a_err_fields, clk, arst_n, is_error, err_clean)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
